/* sv/pairwise_window_match_defines.svh */
// Assertion helpers shared by the RTL of the window match block.
`ifndef PAIRWISE_WINDOW_MATCH_DEFINES_SVH
`define PAIRWISE_WINDOW_MATCH_DEFINES_SVH

// Check on every clock edge out of reset.
`define PWM_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PWM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwm_pkg;

  localparam int MAX_ROWS     = 64;
  localparam int NUM_FEATURES = 4;
  localparam int FEATURE_BITS = 15;

  localparam int LANE_BITS = 16;
  localparam int LIMIT_W   = NUM_FEATURES * LANE_BITS;
  localparam int ROW_W     = NUM_FEATURES * FEATURE_BITS;
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DIFF_W    = FEATURE_BITS + 1;
  localparam int CMP_W     = (DIFF_W > LANE_BITS) ? DIFF_W : LANE_BITS;
  localparam int CFG_W     = 64;
  localparam int CFG_AW    = 2;
  localparam int MASK_W    = NUM_FEATURES;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_AW-1:0] REG_UPPER = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MASK  = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // Every feature difference (new minus old, absolute where masked) within its band.
  function automatic logic in_band(row_t newer, row_t older, limit_t lower,
                                   limit_t upper, logic [MASK_W-1:0] mask);
    logic signed [CMP_W-1:0] d;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    logic [FEATURE_BITS-1:0] a;
    logic [FEATURE_BITS-1:0] b;
    logic ok;
    ok = 1'b1;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      a  = newer[f*FEATURE_BITS +: FEATURE_BITS];
      b  = older[f*FEATURE_BITS +: FEATURE_BITS];
      d  = CMP_W'(signed'({1'b0, a})) - CMP_W'(signed'({1'b0, b}));
      if (mask[f] && d < 0) begin
        d = -d;
      end
      lo = CMP_W'(signed'(lower[f*LANE_BITS +: LANE_BITS]));
      hi = CMP_W'(signed'(upper[f*LANE_BITS +: LANE_BITS]));
      if (d < lo || d > hi) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* sv/pwm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/pairwise_window_match.sv */
// Band similarity join over a growing set of rows. Raise start for one cycle
// while busy is low to transfer a row of four 15-bit features; start_new_set_i
// empties the set first so the row becomes row zero. The row is compared with
// every stored row of the set, oldest first, and one result appears on the
// result ports for each match, each for exactly one cycle under res_valid_o,
// with is_last_o on the final one. A row with no match gives one non-match
// result; a row arriving when 64 rows are held is dropped with overflow_o.
// The receiver cannot stall: sample every res_valid_o cycle. A transferred
// row keeps busy high through the scan of the stored rows and the store of
// the row itself, and no new row is taken until busy falls again;
// an overflowed row does not raise busy and its result follows the transfer
// in the next cycle. The scan is paced by the single read port of the row
// memory, which yields one stored row per cycle. Write the limit and mask
// registers only while busy is low and no results are pending.
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_window_match_defines.svh"

module pairwise_window_match
  import pwm_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // row transfer
  input  wire                     start,
  output logic                    busy,
  input  wire                     start_new_set_i,
  input  wire  [FEATURE_BITS-1:0] feature_0_i,
  input  wire  [FEATURE_BITS-1:0] feature_1_i,
  input  wire  [FEATURE_BITS-1:0] feature_2_i,
  input  wire  [FEATURE_BITS-1:0] feature_3_i,
  // configuration writes
  input  wire                     cfg_we_i,
  input  wire  [CFG_AW-1:0]       cfg_addr_i,
  input  wire  [CFG_W-1:0]        cfg_wdata_i,
  // results
  output logic                    res_valid_o,
  output logic [IDX_W-1:0]        row_index_o,
  output logic [IDX_W-1:0]        partner_index_o,
  output logic                    is_match_o,
  output logic                    is_last_o,
  output logic                    overflow_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;  // wait for a transfer
  localparam logic [1:0] ST_SCAN   = 2'd1;  // issue one stored-row read per cycle
  localparam logic [1:0] ST_WAIT   = 2'd2;  // last read data under comparison
  localparam logic [1:0] ST_FINISH = 2'd3;  // close the row and store it

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;     // rows in the current set
  logic [CNT_W-1:0]  scan_q, scan_d;       // next stored row to read
  logic [CNT_W-1:0]  count_eff;
  row_t              row_q, row_d;         // arriving row, held for the whole scan

  // read data tracking: the RAM read is registered, so data follows the address in the next cycle
  logic              dv_q, dv_d;
  logic [IDX_W-1:0]  dv_idx_q, dv_idx_d;

  // one match held back until we know whether it is the last
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;

  // configuration
  limit_t            lower_q, upper_q;
  logic [MASK_W-1:0] mask_q;

  // result register
  logic              rv_q, rv_d;
  logic [IDX_W-1:0]  rrow_q, rrow_d;
  logic [IDX_W-1:0]  rpart_q, rpart_d;
  logic              rmatch_q, rmatch_d;
  logic              rlast_q, rlast_d;
  logic              rovf_q, rovf_d;

  // memory ports
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr;
  row_t              mem_rdata;
  logic              hit;
  logic              accept;

  pwm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (row_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign count_eff = start_new_set_i ? '0 : count_q;
  assign hit       = dv_q && in_band(row_q, mem_rdata, lower_q, upper_q, mask_q);

  // Configuration registers: the user must write them only while idle (the block does not enforce it), no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
      mask_q  <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOWER: lower_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_UPPER: upper_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_MASK:  mask_q  <= cfg_wdata_i[MASK_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    row_d      = row_q;
    dv_d       = 1'b0;
    dv_idx_d   = dv_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    rv_d       = 1'b0;
    rrow_d     = rrow_q;
    rpart_d    = rpart_q;
    rmatch_d   = rmatch_q;
    rlast_d    = rlast_q;
    rovf_d     = rovf_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = scan_q[IDX_W-1:0];

    // Compare the row returned by the memory; flush the older held match.
    if (hit) begin
      if (pend_q) begin
        rv_d     = 1'b1;
        rrow_d   = count_q[IDX_W-1:0];
        rpart_d  = pend_idx_q;
        rmatch_d = 1'b1;
        rlast_d  = 1'b0;
        rovf_d   = 1'b0;
      end
      pend_d     = 1'b1;
      pend_idx_d = dv_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = count_eff;
          if (count_eff == CNT_W'(MAX_ROWS)) begin
            // store full: drop the row and report it without a scan
            rv_d     = 1'b1;
            rrow_d   = '0;
            rpart_d  = '0;
            rmatch_d = 1'b0;
            rlast_d  = 1'b1;
            rovf_d   = 1'b1;
          end else begin
            row_d   = {feature_3_i, feature_2_i, feature_1_i, feature_0_i};
            pend_d  = 1'b0;
            scan_d  = '0;
            state_d = (count_eff == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_re   = 1'b1;
        dv_d     = 1'b1;
        dv_idx_d = scan_q[IDX_W-1:0];
        scan_d   = scan_q + CNT_W'(1);
        if (scan_q + CNT_W'(1) == count_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // close the row: held match is the last, else a single non-match
        rv_d     = 1'b1;
        rrow_d   = count_q[IDX_W-1:0];
        rpart_d  = pend_q ? pend_idx_q : '0;
        rmatch_d = pend_q;
        rlast_d  = 1'b1;
        rovf_d   = 1'b0;
        pend_d   = 1'b0;
        mem_we   = 1'b1;
        count_d  = count_q + CNT_W'(1);
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      dv_q    <= 1'b0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      dv_q    <= dv_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    dv_idx_q   <= dv_idx_d;
    pend_idx_q <= pend_idx_d;
    rrow_q     <= rrow_d;
    rpart_q    <= rpart_d;
    rmatch_q   <= rmatch_d;
    rlast_q    <= rlast_d;
    rovf_q     <= rovf_d;
  end

  assign res_valid_o     = rv_q;
  assign row_index_o     = rrow_q;
  assign partner_index_o = rpart_q;
  assign is_match_o      = rmatch_q;
  assign is_last_o       = rlast_q;
  assign overflow_o      = rovf_q;

  `PWM_ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_ROWS), "row count beyond capacity")
  `PWM_ASSERT_RST(a_accept_reacts, clk_i, rst_ni, accept |=> (busy || (res_valid_o && overflow_o)), "transferred row neither scanned nor dropped")
  `PWM_ASSERT_RST(a_read_written, clk_i, rst_ni, dv_q |-> ({1'b0, dv_idx_q} < count_q), "read of a row outside the set")
  `PWM_ASSERT_RST(a_write_room, clk_i, rst_ni, mem_we |-> (count_q < CNT_W'(MAX_ROWS)), "row stored into a full set")
  `PWM_ASSERT_RST(a_nomatch_last, clk_i, rst_ni, (res_valid_o && !is_match_o) |-> is_last_o, "non-match result not flagged last")

endmodule

`default_nettype wire
